/* rtl/core/plec_pkg.sv */
package plec_pkg;

  localparam int NDOTS = 9;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] KIND_PRESS   = 3'd0;
  localparam logic [2:0] KIND_RELEASE = 3'd1;
  localparam logic [2:0] KIND_DRAG    = 3'd2;
  localparam logic [2:0] KIND_TICK    = 3'd3;
  localparam logic [2:0] KIND_START   = 3'd4;

  localparam logic [3:0] MSG_NO_PATTERN = 4'd0;
  localparam logic [3:0] MSG_ENTER      = 4'd1;
  localparam logic [3:0] MSG_UNLOCKED   = 4'd2;
  localparam logic [3:0] MSG_WRONG      = 4'd3;
  localparam logic [3:0] MSG_TOO_FEW    = 4'd4;
  localparam logic [3:0] MSG_CONFIRM    = 4'd5;
  localparam logic [3:0] MSG_DRAW_NEW   = 4'd6;
  localparam logic [3:0] MSG_SAVING     = 4'd7;
  localparam logic [3:0] MSG_MISMATCH   = 4'd8;
  localparam logic [3:0] MSG_SAVED      = 4'd9;
  localparam logic [3:0] MSG_SAVE_FAIL  = 4'd10;

  localparam logic [2:0] REG_MIN_LENGTH   = 3'd0;
  localparam logic [2:0] REG_HIT_RADIUS   = 3'd1;
  localparam logic [2:0] REG_SUCCESS_TCK  = 3'd2;
  localparam logic [2:0] REG_ERROR_TCK    = 3'd3;
  localparam logic [2:0] REG_SHOW_TCK     = 3'd4;
  localparam logic [2:0] REG_SAVE_TCK     = 3'd5;

  localparam logic [8:0] DOT_CX [NDOTS] = '{9'd50, 9'd120, 9'd190, 9'd50, 9'd120,
                                            9'd190, 9'd50, 9'd120, 9'd190};
  localparam logic [8:0] DOT_CY [NDOTS] = '{9'd90, 9'd90, 9'd90, 9'd160, 9'd160,
                                            9'd160, 9'd230, 9'd230, 9'd230};

  typedef enum logic [1:0] {
    MODE_LOCKED      = 2'd0,
    MODE_UNLOCKED    = 2'd1,
    MODE_REG_FIRST   = 2'd2,
    MODE_REG_CONFIRM = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ACT_NONE          = 3'd0,
    ACT_LOCK          = 3'd1,
    ACT_REG_AGAIN     = 3'd2,
    ACT_CONFIRM_CLEAR = 3'd3,
    ACT_SAVE          = 3'd4
  } act_t;

  typedef enum logic [1:0] {
    COL_IDLE    = 2'd0,
    COL_ACTIVE  = 2'd1,
    COL_SUCCESS = 2'd2,
    COL_ERROR   = 2'd3
  } color_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       hit_v;
    logic [3:0] hit_idx;
    logic       save_ok;
  } plec_item_t;

  typedef struct packed {
    logic [3:0]  min_length;
    logic [15:0] hit_radius_squared;
    logic [7:0]  win_hold;
    logic [7:0]  fail_hold;
    logic [7:0]  first_hold;
    logic [7:0]  save_hold;
  } plec_cfg_t;

  function automatic logic [1:0] dot_row(input logic [3:0] d);
    case (d)
      4'd0, 4'd1, 4'd2: dot_row = 2'd0;
      4'd3, 4'd4, 4'd5: dot_row = 2'd1;
      default:          dot_row = 2'd2;
    endcase
  endfunction

  function automatic logic [1:0] dot_col(input logic [3:0] d);
    case (d)
      4'd0, 4'd3, 4'd6: dot_col = 2'd0;
      4'd1, 4'd4, 4'd7: dot_col = 2'd1;
      default:          dot_col = 2'd2;
    endcase
  endfunction

endpackage

/* rtl/core/plec_front.sv */
module plec_front (
  input  logic                   in_valid,
  input  logic [2:0]             kind,
  input  logic [8:0]             touch_x,
  input  logic [8:0]             touch_y,
  input  logic                   save_ok,
  input  logic [15:0]            hit_radius_squared,
  output logic                   item_valid,
  output plec_pkg::plec_item_t   item
);
  import plec_pkg::*;

  logic signed [9:0] dx [NDOTS];
  logic signed [9:0] dy [NDOTS];
  logic [8:0]        ax [NDOTS];
  logic [8:0]        ay [NDOTS];
  logic [19:0]       dsq [NDOTS];
  logic [NDOTS-1:0]  near;
  logic              found;
  logic [3:0]        idx;

  always_comb begin
    for (int i = 0; i < NDOTS; i++) begin
      dx[i] = $signed({1'b0, touch_x}) - $signed({1'b0, DOT_CX[i]});
      dy[i] = $signed({1'b0, touch_y}) - $signed({1'b0, DOT_CY[i]});
      ax[i] = dx[i][9] ? 9'(-dx[i]) : dx[i][8:0];
      ay[i] = dy[i][9] ? 9'(-dy[i]) : dy[i][8:0];
      dsq[i] = {2'd0, {9'd0, ax[i]} * {9'd0, ax[i]}} + {2'd0, {9'd0, ay[i]} * {9'd0, ay[i]}};
      near[i] = dsq[i] <= {4'd0, hit_radius_squared};
    end
  end

  // first dot in index order wins
  always_comb begin
    found = 1'b0;
    idx = 4'd0;
    for (int i = NDOTS - 1; i >= 0; i--) begin
      if (near[i]) begin
        found = 1'b1;
        idx = 4'(i);
      end
    end
  end

  assign item_valid   = in_valid;
  assign item.kind    = kind;
  assign item.hit_v   = found;
  assign item.hit_idx = idx;
  assign item.save_ok = save_ok;

endmodule

/* rtl/core/plec_fifo.sv */
module plec_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  input  plec_pkg::plec_item_t wr_item,
  output logic                 rd_valid,
  input  logic                 rd_ready,
  output plec_pkg::plec_item_t rd_item
);
  import plec_pkg::*;

  plec_item_t mem [QUEUE_DEPTH];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign wr_ready = cnt_r != 2'(QUEUE_DEPTH);
  assign rd_valid = cnt_r != 2'd0;
  assign rd_item  = mem[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/core/plec_back.sv */
module plec_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  plec_pkg::plec_cfg_t  cfg,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  plec_pkg::plec_item_t item,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata
);
  import plec_pkg::*;

  mode_t       mode_r, mode_nxt;
  act_t        act_r, act_nxt;
  color_t      color_r, color_nxt;
  logic [7:0]  timer_r, timer_nxt;
  logic [3:0]  seq_r [NDOTS];
  logic [3:0]  seq_nxt [NDOTS];
  logic [3:0]  first_r [NDOTS];
  logic [3:0]  saved_r [NDOTS];
  logic [3:0]  len_r, len_nxt, first_len_r, saved_len_r;
  logic [3:0]  last_r, last_nxt;
  logic [8:0]  used_r, used_nxt;
  logic        drag_r, drag_nxt, valid_r, valid_nxt;
  logic [3:0]  status_r, status_nxt;
  logic        out_valid_r;
  logic [31:0] out_data_r;

  logic        pop;
  logic        press_ok, release_ok, fin, drag_ok, tick_fire, start_ok;
  logic        long_enough, match_saved, match_first;
  logic        unlock_ok, copy_first, save_now;
  logic [3:0]  base_len, mid, len_m, b, out_last;
  logic [8:0]  base_used;
  logic [2:0]  sr, sc;
  logic        tp, ins_mid, add_b;

  assign pop        = item_valid && (!out_valid_r || out_tready);
  assign item_ready = pop;
  assign b          = item.hit_idx;

  // event decode
  always_comb begin
    press_ok   = item.kind == KIND_PRESS && timer_r == 8'd0 && mode_r != MODE_UNLOCKED &&
                 !(mode_r == MODE_LOCKED && !valid_r);
    release_ok = item.kind == KIND_RELEASE && timer_r == 8'd0 && drag_r;
    fin        = release_ok && len_r != 4'd0;
    drag_ok    = item.kind == KIND_DRAG && drag_r;
    tick_fire  = item.kind == KIND_TICK && timer_r == 8'd1;
    start_ok   = item.kind == KIND_START &&
                 (mode_r == MODE_LOCKED || mode_r == MODE_UNLOCKED);
    long_enough = len_r >= cfg.min_length;
    match_saved = saved_len_r == len_r;
    match_first = first_len_r == len_r;
    for (int i = 0; i < NDOTS; i++) begin
      if (4'(i) < len_r && seq_r[i] != saved_r[i]) match_saved = 1'b0;
      if (4'(i) < len_r && seq_r[i] != first_r[i]) match_first = 1'b0;
    end
    unlock_ok  = fin && mode_r == MODE_LOCKED && long_enough && valid_r && match_saved;
    copy_first = fin && mode_r == MODE_REG_FIRST && long_enough;
    save_now   = tick_fire && act_r == ACT_SAVE && item.save_ok;
  end

  // mode next state
  always_comb begin
    mode_nxt = mode_r;
    if (unlock_ok) begin
      mode_nxt = MODE_UNLOCKED;
    end else if (copy_first) begin
      mode_nxt = MODE_REG_CONFIRM;
    end else if (tick_fire) begin
      unique case (act_r)
        ACT_LOCK:      mode_nxt = MODE_LOCKED;
        ACT_REG_AGAIN: mode_nxt = MODE_REG_FIRST;
        ACT_SAVE:      mode_nxt = item.save_ok ? MODE_LOCKED : MODE_REG_FIRST;
        default:       mode_nxt = mode_r;
      endcase
    end else if (start_ok) begin
      mode_nxt = MODE_REG_FIRST;
    end
  end

  // touch point path
  always_comb begin
    base_len  = press_ok ? 4'd0 : len_r;
    base_used = press_ok ? 9'd0 : used_r;
    sr  = {1'b0, dot_row(last_r)} + {1'b0, dot_row(b)};
    sc  = {1'b0, dot_col(last_r)} + {1'b0, dot_col(b)};
    mid = {1'b0, sr[2:1], 1'b0} + {2'b0, sr[2:1]} + {2'b0, sc[2:1]};
    tp  = (press_ok || drag_ok) && item.hit_v && !base_used[b];
    ins_mid = tp && base_len != 4'd0 && !sr[0] && !sc[0] && mid != last_r && mid != b &&
              mid < 4'(NDOTS) && !base_used[mid] && base_len < 4'(NDOTS);
    len_m = base_len + {3'd0, ins_mid};
    add_b = tp && len_m < 4'(NDOTS);
  end

  // outputs and datapath state
  always_comb begin
    act_nxt    = act_r;
    color_nxt  = color_r;
    timer_nxt  = timer_r;
    len_nxt    = len_r;
    last_nxt   = last_r;
    used_nxt   = used_r;
    drag_nxt   = drag_r;
    status_nxt = status_r;
    valid_nxt  = valid_r;
    seq_nxt    = seq_r;
    case (item.kind)
      KIND_PRESS, KIND_DRAG: begin
        if (press_ok) begin
          len_nxt   = 4'd0;
          used_nxt  = 9'd0;
          color_nxt = COL_IDLE;
          drag_nxt  = 1'b1;
        end
        if (ins_mid) begin
          seq_nxt[base_len] = mid;
          used_nxt  = base_used | (9'd1 << mid);
          last_nxt  = mid;
          len_nxt   = len_m;
          color_nxt = COL_ACTIVE;
        end
        if (add_b) begin
          seq_nxt[len_m] = b;
          used_nxt  = base_used | (ins_mid ? (9'd1 << mid) : 9'd0) | (9'd1 << b);
          last_nxt  = b;
          len_nxt   = len_m + 4'd1;
          color_nxt = COL_ACTIVE;
        end
      end
      KIND_RELEASE: begin
        if (release_ok) drag_nxt = 1'b0;
        if (fin) begin
          case (mode_r)
            MODE_LOCKED: begin
              act_nxt = ACT_LOCK;
              if (unlock_ok) begin
                color_nxt = COL_SUCCESS; status_nxt = MSG_UNLOCKED;
                timer_nxt = cfg.win_hold;
              end else begin
                color_nxt = COL_ERROR; status_nxt = MSG_WRONG;
                timer_nxt = cfg.fail_hold;
              end
            end
            MODE_REG_FIRST: begin
              if (copy_first) begin
                color_nxt = COL_ACTIVE; status_nxt = MSG_CONFIRM;
                act_nxt = ACT_CONFIRM_CLEAR; timer_nxt = cfg.first_hold;
              end else begin
                color_nxt = COL_ERROR; status_nxt = MSG_TOO_FEW;
                act_nxt = ACT_REG_AGAIN; timer_nxt = cfg.fail_hold;
              end
            end
            MODE_REG_CONFIRM: begin
              if (match_first) begin
                color_nxt = COL_ACTIVE; status_nxt = MSG_SAVING;
                act_nxt = ACT_SAVE; timer_nxt = cfg.save_hold;
              end else begin
                color_nxt = COL_ERROR; status_nxt = MSG_MISMATCH;
                act_nxt = ACT_REG_AGAIN; timer_nxt = cfg.fail_hold;
              end
            end
            default: ;
          endcase
        end
      end
      KIND_TICK: begin
        if (timer_r != 8'd0) timer_nxt = timer_r - 8'd1;
        if (tick_fire) begin
          act_nxt = ACT_NONE;
          case (act_r)
            ACT_LOCK: begin
              len_nxt = 4'd0; used_nxt = 9'd0; color_nxt = COL_IDLE; drag_nxt = 1'b0;
              timer_nxt = 8'd0;
              status_nxt = valid_r ? MSG_ENTER : MSG_NO_PATTERN;
            end
            ACT_REG_AGAIN: begin
              len_nxt = 4'd0; used_nxt = 9'd0; color_nxt = COL_IDLE;
              status_nxt = MSG_DRAW_NEW;
            end
            ACT_CONFIRM_CLEAR: begin
              len_nxt = 4'd0; used_nxt = 9'd0; color_nxt = COL_IDLE;
              status_nxt = MSG_CONFIRM;
            end
            ACT_SAVE: begin
              if (item.save_ok) begin
                valid_nxt = 1'b1;
                color_nxt = COL_SUCCESS; status_nxt = MSG_SAVED;
                act_nxt = ACT_LOCK; timer_nxt = cfg.win_hold;
              end else begin
                color_nxt = COL_ERROR; status_nxt = MSG_SAVE_FAIL;
                act_nxt = ACT_REG_AGAIN; timer_nxt = cfg.fail_hold;
              end
            end
            default: ;
          endcase
        end
      end
      KIND_START: begin
        if (start_ok) begin
          len_nxt = 4'd0; used_nxt = 9'd0; color_nxt = COL_IDLE; drag_nxt = 1'b0;
          act_nxt = ACT_NONE; timer_nxt = 8'd0; status_nxt = MSG_DRAW_NEW;
        end
      end
      default: ;
    endcase
    out_last = (len_nxt == 4'd0) ? 4'd0 : last_nxt;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      seq_r <= seq_nxt;
      if (copy_first) begin
        first_r <= seq_r;
      end
      if (save_now) begin
        saved_r <= first_r;
      end
      last_r <= last_nxt;
    end
    if (pop) begin
      out_data_r <= {5'd0, valid_nxt, timer_nxt != 8'd0, color_nxt, out_last, used_nxt,
                     len_nxt, status_nxt, mode_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_LOCKED;
      act_r       <= ACT_NONE;
      color_r     <= COL_IDLE;
      timer_r     <= 8'd0;
      len_r       <= 4'd0;
      used_r      <= 9'd0;
      drag_r      <= 1'b0;
      status_r    <= MSG_NO_PATTERN;
      valid_r     <= 1'b0;
      first_len_r <= 4'd0;
      saved_len_r <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        mode_r   <= mode_nxt;
        act_r    <= act_nxt;
        color_r  <= color_nxt;
        timer_r  <= timer_nxt;
        len_r    <= len_nxt;
        used_r   <= used_nxt;
        drag_r   <= drag_nxt;
        status_r <= status_nxt;
        valid_r  <= valid_nxt;
        if (copy_first) first_len_r <= len_r;
        if (save_now) saved_len_r <= (first_len_r > 4'(NDOTS)) ? 4'(NDOTS) : first_len_r;
      end
      if (pop) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  a_mask_len: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(used_r) == 32'(len_r))
    else $error("dot mask and length disagree");
  a_timer_act: assert property (@(posedge clk) disable iff (!rst_n)
    timer_r != 8'd0 |-> act_r != ACT_NONE)
    else $error("timer running with no pending action");
  a_unlock_saved: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_UNLOCKED |-> valid_r)
    else $error("unlocked without stored pattern");
  a_pop_out: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid_r)
    else $error("popped item produced no result");
`endif

endmodule

/* rtl/core/pattern_lock_entry_controller_core.sv */
// an accepted item goes into a queue entry, then its result into the output register
// one item per cycle when not stalled; 2-entry queue between hit test and state update
// output register holds a result while the next item is already taken
// reset: synchronous active-low rst_n; config returns to defaults, no stored pattern
module pattern_lock_entry_controller_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // touch_x, touch_y, save_ok
  input  logic [2:0]  in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // mode, status_message, pattern_length, dot_mask,
                                  // last_dot, color_class, busy_res, pattern_stored
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import plec_pkg::*;

  plec_cfg_t  cfg_r;
  plec_item_t f_item, q_item;
  logic       f_valid, q_valid, q_ready;
  logic       wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_length         <= 4'd4;
      cfg_r.hit_radius_squared <= 16'd484;
      cfg_r.win_hold           <= 8'd180;
      cfg_r.fail_hold          <= 8'd90;
      cfg_r.first_hold         <= 8'd60;
      cfg_r.save_hold          <= 8'd2;
    end else if (wr_en) begin
      unique case (cfg_paddr[4:2])
        REG_MIN_LENGTH:  cfg_r.min_length         <= cfg_pwdata[3:0];
        REG_HIT_RADIUS:  cfg_r.hit_radius_squared <= cfg_pwdata[15:0];
        REG_SUCCESS_TCK: cfg_r.win_hold           <= cfg_pwdata[7:0];
        REG_ERROR_TCK:   cfg_r.fail_hold          <= cfg_pwdata[7:0];
        REG_SHOW_TCK:    cfg_r.first_hold         <= cfg_pwdata[7:0];
        REG_SAVE_TCK:    cfg_r.save_hold          <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:2])
      REG_MIN_LENGTH:  cfg_prdata = {28'd0, cfg_r.min_length};
      REG_HIT_RADIUS:  cfg_prdata = {16'd0, cfg_r.hit_radius_squared};
      REG_SUCCESS_TCK: cfg_prdata = {24'd0, cfg_r.win_hold};
      REG_ERROR_TCK:   cfg_prdata = {24'd0, cfg_r.fail_hold};
      REG_SHOW_TCK:    cfg_prdata = {24'd0, cfg_r.first_hold};
      REG_SAVE_TCK:    cfg_prdata = {24'd0, cfg_r.save_hold};
      default:         cfg_prdata = 32'd0;
    endcase
  end

  plec_front u_front (
    .in_valid           (in_tvalid),
    .kind               (in_tuser),
    .touch_x            (in_tdata[8:0]),
    .touch_y            (in_tdata[17:9]),
    .save_ok            (in_tdata[18]),
    .hit_radius_squared (cfg_r.hit_radius_squared),
    .item_valid         (f_valid),
    .item               (f_item)
  );

  plec_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (in_tready),
    .wr_item  (f_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  plec_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* sim/plec_checker.sv */
`timescale 1ns / 100ps

module plec_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // touch_x, touch_y, save_ok
  input  logic [2:0]  in_tuser,   // kind
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // mode, status_message, pattern_length, dot_mask,
                                  // last_dot, color_class, busy_res, pattern_stored
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending
);
  import plec_pkg::*;

  logic [3:0]  min_len;
  logic [15:0] radius_sq;
  logic [7:0]  succ_ticks, err_ticks, show_ticks, save_ticks;

  mode_t      mode;
  act_t       action;
  logic [7:0] msg_timer;
  logic [3:0] seq_dots [NDOTS];
  logic [3:0] first_dots [NDOTS];
  logic [3:0] saved_dots [NDOTS];
  logic [3:0] seq_len, first_len, saved_len;
  logic [8:0] used;
  logic       drawing, have_saved;
  logic [3:0] status;
  color_t     color;

  logic [31:0] expected_q [$];

  task automatic clear_drawing();
    seq_len = 0;
    used = '0;
    color = COL_IDLE;
  endtask

  task automatic add_dot(input int idx);
    if (idx < NDOTS && seq_len < NDOTS) begin
      used[idx] = 1'b1;
      seq_dots[seq_len] = idx[3:0];
      seq_len = seq_len + 4'd1;
      color = COL_ACTIVE;
    end
  endtask

  task automatic take_point(input logic [8:0] x, input logic [8:0] y);
    int h, dx, dy, a, sr, sc, mid;
    h = -1;
    for (int i = 0; i < NDOTS; i++) begin
      dx = int'(x) - int'(DOT_CX[i]);
      dy = int'(y) - int'(DOT_CY[i]);
      if (h < 0 && dx * dx + dy * dy <= int'(radius_sq)) h = i;
    end
    if (h >= 0 && !used[h]) begin
      if (seq_len > 0) begin
        a = int'(seq_dots[seq_len - 4'd1]);
        sr = a / 3 + h / 3;
        sc = a % 3 + h % 3;
        if (sr % 2 == 0 && sc % 2 == 0) begin
          mid = (sr / 2) * 3 + sc / 2;
          if (mid != a && mid != h && !used[mid]) add_dot(mid);
        end
      end
      add_dot(h);
    end
  endtask

  task automatic set_outcome(input color_t c, input logic [3:0] msg, input act_t a,
                             input logic [7:0] ticks);
    color = c;
    status = msg;
    action = a;
    msg_timer = ticks;
  endtask

  function automatic logic matches_first();
    if (first_len != seq_len) return 1'b0;
    for (int i = 0; i < NDOTS; i++)
      if (i < seq_len && seq_dots[i] != first_dots[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic matches_saved();
    if (saved_len != seq_len) return 1'b0;
    for (int i = 0; i < NDOTS; i++)
      if (i < seq_len && seq_dots[i] != saved_dots[i]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic end_stroke();
    drawing = 1'b0;
    if (seq_len != 0) begin
      if (mode == MODE_LOCKED) begin
        if (seq_len >= min_len && have_saved && matches_saved()) begin
          mode = MODE_UNLOCKED;
          set_outcome(COL_SUCCESS, MSG_UNLOCKED, ACT_LOCK, succ_ticks);
        end else begin
          set_outcome(COL_ERROR, MSG_WRONG, ACT_LOCK, err_ticks);
        end
      end else if (mode == MODE_REG_FIRST) begin
        if (seq_len < min_len) begin
          set_outcome(COL_ERROR, MSG_TOO_FEW, ACT_REG_AGAIN, err_ticks);
        end else begin
          first_dots = seq_dots;
          first_len = seq_len;
          mode = MODE_REG_CONFIRM;
          set_outcome(COL_ACTIVE, MSG_CONFIRM, ACT_CONFIRM_CLEAR, show_ticks);
        end
      end else if (mode == MODE_REG_CONFIRM) begin
        if (matches_first()) set_outcome(COL_ACTIVE, MSG_SAVING, ACT_SAVE, save_ticks);
        else set_outcome(COL_ERROR, MSG_MISMATCH, ACT_REG_AGAIN, err_ticks);
      end
    end
  endtask

  task automatic fire_action(input logic save_ok);
    act_t a;
    a = action;
    action = ACT_NONE;
    case (a)
      ACT_LOCK: begin
        clear_drawing();
        drawing = 1'b0;
        mode = MODE_LOCKED;
        msg_timer = 0;
        status = have_saved ? MSG_ENTER : MSG_NO_PATTERN;
      end
      ACT_REG_AGAIN: begin
        clear_drawing();
        mode = MODE_REG_FIRST;
        status = MSG_DRAW_NEW;
      end
      ACT_CONFIRM_CLEAR: begin
        clear_drawing();
        status = MSG_CONFIRM;
      end
      ACT_SAVE: begin
        if (save_ok) begin
          saved_dots = first_dots;
          saved_len = first_len;
          have_saved = 1'b1;
          mode = MODE_LOCKED;
          set_outcome(COL_SUCCESS, MSG_SAVED, ACT_LOCK, succ_ticks);
        end else begin
          mode = MODE_REG_FIRST;
          set_outcome(COL_ERROR, MSG_SAVE_FAIL, ACT_REG_AGAIN, err_ticks);
        end
      end
      default: ;
    endcase
  endtask

  task automatic apply_event(input logic [2:0] kind, input logic [8:0] x,
                             input logic [8:0] y, input logic save_ok,
                             output logic [31:0] res);
    logic [3:0] last;
    case (kind)
      KIND_PRESS:
        if (msg_timer == 0 && mode != MODE_UNLOCKED &&
            !(mode == MODE_LOCKED && !have_saved)) begin
          clear_drawing();
          drawing = 1'b1;
          take_point(x, y);
        end
      KIND_RELEASE: if (msg_timer == 0 && drawing) end_stroke();
      KIND_DRAG: if (drawing) take_point(x, y);
      KIND_TICK:
        if (msg_timer != 0) begin
          msg_timer = msg_timer - 8'd1;
          if (msg_timer == 0) fire_action(save_ok);
        end
      KIND_START:
        if (mode != MODE_REG_FIRST && mode != MODE_REG_CONFIRM) begin
          clear_drawing();
          drawing = 1'b0;
          mode = MODE_REG_FIRST;
          action = ACT_NONE;
          msg_timer = 0;
          status = MSG_DRAW_NEW;
        end
      default: ;
    endcase
    last = (seq_len != 0) ? seq_dots[seq_len - 4'd1] : 4'd0;
    res = {5'd0, have_saved, msg_timer != 0, color, last, used, seq_len, status, mode};
  endtask

  always @(posedge clk) begin
    logic [31:0] res;
    logic [31:0] want;
    if (!rst_n) begin
      min_len = 4;
      radius_sq = 484;
      succ_ticks = 180;
      err_ticks = 90;
      show_ticks = 60;
      save_ticks = 2;
      mode = MODE_LOCKED;
      action = ACT_NONE;
      msg_timer = 0;
      seq_len = 0;
      first_len = 0;
      saved_len = 0;
      used = '0;
      drawing = 1'b0;
      have_saved = 1'b0;
      status = MSG_NO_PATTERN;
      color = COL_IDLE;
      expected_q.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          REG_MIN_LENGTH:  min_len = cfg_pwdata[3:0];
          REG_HIT_RADIUS:  radius_sq = cfg_pwdata[15:0];
          REG_SUCCESS_TCK: succ_ticks = cfg_pwdata[7:0];
          REG_ERROR_TCK:   err_ticks = cfg_pwdata[7:0];
          REG_SHOW_TCK:    show_ticks = cfg_pwdata[7:0];
          REG_SAVE_TCK:    save_ticks = cfg_pwdata[7:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (want !== out_tdata) begin
            $display("%0t: result mismatch, expected mode %0d msg %0d len %0d mask %h last %0d",
                     $time, want[1:0], want[5:2], want[9:6], want[18:10], want[22:19]);
            $display("%0t:   expected color %0d busy %0d stored %0d, actual %h expected %h",
                     $time, want[24:23], want[25], want[26], out_tdata, want);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        apply_event(in_tuser, in_tdata[8:0], in_tdata[17:9], in_tdata[18], res);
        expected_q.push_back(res);
      end
      pending <= expected_q.size();
    end
  end

endmodule

/* sim/tb_pattern_lock_entry_controller_core.sv */
`timescale 1ns / 100ps

module tb_pattern_lock_entry_controller_core;
  import plec_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid, in_tready;
  logic [23:0] in_tdata;   // touch_x, touch_y, save_ok
  logic [2:0]  in_tuser;   // kind
  logic        out_tvalid, out_tready;
  logic [31:0] out_tdata;  // mode, status_message, pattern_length, dot_mask,
                           // last_dot, color_class, busy_res, pattern_stored
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  int          fail_count, pending;

  int          sent;
  int          tick_span;
  int          memo [$];
  logic        calm;
  int          stall_left, calm_cnt;

  always #1 clk = ~clk;

  pattern_lock_entry_controller_core dut (.*);

  plec_checker chk (.*);

  initial begin
    #2000000;
    $display("pattern_lock_entry_controller_core verification failed");
    $finish;
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
      calm_cnt <= 0;
      calm <= 1'b0;
    end else begin
      calm_cnt <= calm_cnt + 1;
      if (calm_cnt % 300 == 299) calm <= ($urandom_range(0, 2) == 0);
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_tready <= 1'b0;
      end else if (calm || $urandom_range(0, 3) != 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 50)
                                                   : $urandom_range(0, 2);
      end
    end
  end

  task automatic send_item(input logic [2:0] kind, input int x, input int y,
                           input logic save_ok);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {5'd0, save_ok, y[8:0], x[8:0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
    if (calm) gap = 0;
    else if ($urandom_range(0, 15) == 0) gap = $urandom_range(8, 40);
    else gap = $urandom_range(0, 2);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic touch_dot(input logic [2:0] kind, input int dot, input int jit);
    int x, y;
    x = int'(DOT_CX[dot]) + $urandom_range(0, 2 * jit) - jit;
    y = int'(DOT_CY[dot]) + $urandom_range(0, 2 * jit) - jit;
    send_item(kind, x, y, 1'($urandom_range(0, 1)));
  endtask

  task automatic draw_dots(input int dots [$], input int jit);
    touch_dot(KIND_PRESS, dots[0], jit);
    for (int i = 1; i < dots.size(); i++) touch_dot(KIND_DRAG, dots[i], jit);
    send_item(KIND_RELEASE, $urandom_range(0, 511), $urandom_range(0, 511),
              1'($urandom_range(0, 1)));
  endtask

  task automatic tick_run(input int n, input logic save_ok);
    repeat (n) send_item(KIND_TICK, $urandom_range(0, 511), $urandom_range(0, 511), save_ok);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int ml, input int rad, input int st, input int et,
                           input int sh, input int sv);
    settle();
    cfg_write(REG_MIN_LENGTH, ml);
    cfg_write(REG_HIT_RADIUS, rad);
    cfg_write(REG_SUCCESS_TCK, st);
    cfg_write(REG_ERROR_TCK, et);
    cfg_write(REG_SHOW_TCK, sh);
    cfg_write(REG_SAVE_TCK, sv);
    tick_span = st;
    if (et > tick_span) tick_span = et;
    if (sh > tick_span) tick_span = sh;
  endtask

  task automatic random_part(input int budget, input int jit);
    int stop, r, n, left;
    int dots [$];
    stop = sent + budget;
    while (sent < stop) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        dots.delete();
        if (memo.size() > 0 && $urandom_range(0, 9) < 6) begin
          dots = memo;
        end else begin
          n = $urandom_range(1, 9);
          repeat (n) dots.push_back($urandom_range(0, NDOTS - 1));
          if ($urandom_range(0, 1) == 0) memo = dots;
        end
        if ($urandom_range(0, 9) == 0)
          send_item(KIND_PRESS, $urandom_range(0, 511), $urandom_range(0, 511), 1'b0);
        draw_dots(dots, ($urandom_range(0, 3) == 0) ? 0 : jit);
        left = stop - sent;
        if (left < 0) left = 0;
        n = $urandom_range(0, tick_span + 2);
        if (n > left) n = left;
        tick_run(n, $urandom_range(0, 9) < 7);
      end else if (r < 75) begin
        send_item(KIND_START, $urandom_range(0, 511), $urandom_range(0, 511),
                  1'($urandom_range(0, 1)));
      end else if (r < 85) begin
        left = stop - sent;
        n = $urandom_range(1, tick_span + 1);
        if (n > left) n = left;
        tick_run(n, 1'($urandom_range(0, 1)));
      end else begin
        send_item(3'($urandom_range(0, 7)), $urandom_range(0, 511), $urandom_range(0, 511),
                  1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    int zsl [$];
    int shape [$];
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    sent = 0;
    tick_span = 180;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    configure(4, 484, 3, 2, 2, 1);
    // directed: ignored kinds and inputs while nothing is drawn, then a start
    send_item(3'd5, 0, 511, 1'b1);
    send_item(3'd7, 511, 0, 1'b0);
    touch_dot(KIND_PRESS, 0, 0);
    send_item(KIND_DRAG, 120, 90, 1'b0);
    send_item(KIND_RELEASE, 0, 0, 1'b0);
    send_item(KIND_TICK, 0, 0, 1'b1);
    send_item(KIND_START, 0, 0, 1'b0);
    // corner to corner strokes pull in the skipped middle dots
    zsl = '{0, 2, 8, 6};
    draw_dots(zsl, 0);
    tick_run(2, 1'b0);
    draw_dots(zsl, 5);
    tick_run(1, 1'b1);
    tick_run(3, 1'b0);
    memo = '{0, 1, 2, 8, 7, 6};
    draw_dots(memo, 10);
    // press while unlocked and with timer running
    touch_dot(KIND_PRESS, 4, 0);
    send_item(KIND_START, 0, 0, 1'b0);
    shape = '{4};
    draw_dots(shape, 0);
    tick_run(3, 1'b1);

    random_part(45, 12);
    // sender holds back until every result is back
    settle();
    random_part(20, 12);

    configure(1, 0, 1, 1, 1, 1);
    random_part(45, 1);
    configure(9, 65535, 5, 4, 3, 2);
    random_part(45, 30);
    configure(2, 900, 255, 255, 255, 255);
    random_part(10, 20);
    tick_run(260, 1'b1);
    configure(3, 1500, 6, 20, 1, 12);
    random_part(50, 25);

    settle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("pattern_lock_entry_controller_core verification clean");
    end else begin
      $display("pattern_lock_entry_controller_core verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/plec_pkg.sv
rtl/core/plec_front.sv
rtl/core/plec_fifo.sv
rtl/core/plec_back.sv
rtl/core/pattern_lock_entry_controller_core.sv
sim/plec_checker.sv
sim/tb_pattern_lock_entry_controller_core.sv
